// ===== rtl/rtxt_pkg.sv =====
`default_nettype none

package rtxt_pkg;

    localparam int unsigned NUM_WIDTH   = 32;
    localparam int unsigned DIGIT_WIDTH = 4;
    localparam int unsigned RADIX_WIDTH = 5;
    localparam int unsigned STACK_DEPTH = 32;
    localparam int unsigned SYM_SLOTS   = 16;

    localparam logic [7:0] CH_PLUS    = 8'd43;
    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_NEWLINE = 8'd10;

    localparam logic [1:0] REG_BASE_SIZE    = 2'd0;
    localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SIGN,
        ST_DIV,
        ST_DIV_WAIT,
        ST_DIGIT,
        ST_NEWLINE
    } rtxt_state_t;

    typedef struct packed {
        logic                   start;
        logic [NUM_WIDTH-1:0]   dividend;
        logic [RADIX_WIDTH-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                   done;
        logic [NUM_WIDTH-1:0]   quotient;
        logic [RADIX_WIDTH-1:0] remainder;
    } div_rsp_t;

    function automatic logic [7:0] symbol_at(input logic [127:0] symbols,
                                             input logic [DIGIT_WIDTH-1:0] idx);
        return symbols[{idx, 3'b000} +: 8];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/signed_integer_to_radix_text_unit.sv =====
`default_nettype none

// Converts one signed 32-bit number per input beat into text in a base set by a
// programmable alphabet of up to 16 byte symbols, and sends it one byte per output
// beat: '-' for negatives, the digit symbols most significant first, then a newline
// flagged by m_tlast. An alphabet shorter than two symbols, with a repeated symbol,
// or holding '+' or '-' makes the number produce no output. Digits come from one
// shared restoring divider that retires one quotient bit per cycle, so each digit
// takes a start, 32 bit steps and a write-back. A binary result has up to 32 digits,
// and output back-pressure can stall an item. s_tready is high only between items.
// Program the alphabet while the block is idle.
module signed_integer_to_radix_text_unit
    import rtxt_pkg::*;
#(
    parameter int unsigned MAX_SYMBOLS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wr_data,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] number

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] text_byte
    output logic             m_tlast    // last_byte
);

    rtxt_state_t state_reg, state_next;

    logic [RADIX_WIDTH-1:0] base_reg;
    logic [63:0]            sym_lo_reg;
    logic [63:0]            sym_hi_reg;
    logic [127:0]           symbols;

    logic [NUM_WIDTH-1:0]   mag_reg, mag_next;
    logic                   neg_reg, neg_next;

    logic                   out_valid_reg, out_valid_next;
    logic [7:0]             out_data_reg,  out_data_next;
    logic                   out_last_reg,  out_last_next;

    logic                   out_free;
    logic                   emit;
    logic [7:0]             emit_byte;
    logic                   emit_last;

    logic                   alpha_ok;
    div_req_t               div_req;
    div_rsp_t               div_rsp;

    logic                   push;
    logic                   pop;
    logic [DIGIT_WIDTH-1:0] top_digit;
    logic                   stack_empty;

    assign symbols = {sym_hi_reg, sym_lo_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= '0;
            sym_lo_reg <= '0;
            sym_hi_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BASE_SIZE:    base_reg   <= cfg_wr_data[RADIX_WIDTH-1:0];
                REG_SYMBOLS_LOW:  sym_lo_reg <= cfg_wr_data;
                REG_SYMBOLS_HIGH: sym_hi_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    rtxt_alpha_check #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .base_size(base_reg),
        .symbols  (symbols),
        .alpha_ok (alpha_ok)
    );

    rtxt_divider u_div (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (div_req),
        .rsp    (div_rsp)
    );

    rtxt_digit_stack u_stack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_digit(div_rsp.remainder[DIGIT_WIDTH-1:0]),
        .pop       (pop),
        .top_digit (top_digit),
        .empty     (stack_empty)
    );

    assign out_free = !out_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!alpha_ok)    state_next = ST_IDLE;
                else if (neg_reg) state_next = ST_SIGN;
                else              state_next = ST_DIV;
            end
            ST_SIGN: begin
                if (out_free) state_next = ST_DIV;
            end
            ST_DIV: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    state_next = (div_rsp.quotient == '0) ? ST_DIGIT : ST_DIV;
                end
            end
            ST_DIGIT: begin
                if (stack_empty) state_next = ST_NEWLINE;
            end
            ST_NEWLINE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        s_tready         = 1'b0;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        div_req.start    = 1'b0;
        div_req.dividend = mag_reg;
        div_req.divisor  = base_reg;
        push             = 1'b0;
        pop              = 1'b0;
        emit             = 1'b0;
        emit_byte        = CH_NEWLINE;
        emit_last        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                neg_next = s_tdata[NUM_WIDTH-1];
                mag_next = s_tdata[NUM_WIDTH-1] ? (~s_tdata + NUM_WIDTH'(1)) : s_tdata;
            end
            ST_CHECK: ;
            ST_SIGN: begin
                emit      = out_free;
                emit_byte = CH_MINUS;
            end
            ST_DIV: begin
                div_req.start = 1'b1;
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    push     = 1'b1;
                    mag_next = div_rsp.quotient;
                end
            end
            ST_DIGIT: begin
                if (!stack_empty && out_free) begin
                    emit      = 1'b1;
                    pop       = 1'b1;
                    emit_byte = symbol_at(symbols, top_digit);
                end
            end
            ST_NEWLINE: begin
                emit      = out_free;
                emit_byte = CH_NEWLINE;
                emit_last = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (emit) begin
            out_valid_next = 1'b1;
            out_data_next  = emit_byte;
            out_last_next  = emit_last;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/rtxt_divider.sv =====
`default_nettype none

module rtxt_divider
    import rtxt_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire div_req_t req,
    output div_rsp_t  rsp
);

    logic                   busy_reg,  busy_next;
    logic                   done_reg,  done_next;
    logic [4:0]             cnt_reg,   cnt_next;
    logic [NUM_WIDTH-1:0]   quo_reg,   quo_next;
    logic [RADIX_WIDTH-1:0] rem_reg,   rem_next;
    logic [RADIX_WIDTH-1:0] div_reg,   div_next;
    logic [RADIX_WIDTH:0]   trial;
    logic                   fits;

    assign trial = {rem_reg, quo_reg[NUM_WIDTH-1]};
    assign fits  = trial >= {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[NUM_WIDTH-2:0], fits};
            rem_next = fits ? RADIX_WIDTH'(trial - {1'b0, div_reg})
                            : trial[RADIX_WIDTH-1:0];
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(NUM_WIDTH - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

// ===== rtl/rtxt_alpha_check.sv =====
`default_nettype none

module rtxt_alpha_check
    import rtxt_pkg::*;
#(
    parameter int unsigned MAX_SYMBOLS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic [RADIX_WIDTH-1:0] base_size,
    input  wire logic [127:0]           symbols,
    output logic                        alpha_ok
);

    logic ok_reg;
    logic ok_next;

    always_comb begin
        ok_next = (base_size >= RADIX_WIDTH'(2))
               && (base_size <= RADIX_WIDTH'(MAX_SYMBOLS))
               && (base_size <= RADIX_WIDTH'(SYM_SLOTS));
        for (int a = 0; a < SYM_SLOTS; a++) begin
            if (RADIX_WIDTH'(a) < base_size) begin
                if (symbols[a*8 +: 8] == CH_PLUS || symbols[a*8 +: 8] == CH_MINUS) begin
                    ok_next = 1'b0;
                end
                for (int b = 0; b < a; b++) begin
                    if (symbols[b*8 +: 8] == symbols[a*8 +: 8]) begin
                        ok_next = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ok_reg <= 1'b0;
        end else begin
            ok_reg <= ok_next;
        end
    end

    assign alpha_ok = ok_reg;

endmodule

`default_nettype wire

// ===== rtl/rtxt_digit_stack.sv =====
`default_nettype none

module rtxt_digit_stack
    import rtxt_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   push,
    input  wire logic [DIGIT_WIDTH-1:0] push_digit,
    input  wire logic                   pop,
    output logic [DIGIT_WIDTH-1:0]      top_digit,
    output logic                        empty
);

    localparam int unsigned IDX_W = $clog2(STACK_DEPTH);

    logic [DIGIT_WIDTH-1:0] mem_reg [STACK_DEPTH];
    logic [IDX_W:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]       top_idx;

    assign top_idx   = cnt_reg[IDX_W-1:0] - IDX_W'(1);
    assign top_digit = mem_reg[top_idx];
    assign empty     = (cnt_reg == '0);

    always_comb begin
        cnt_next = cnt_reg;
        if (push) begin
            cnt_next = cnt_reg + (IDX_W+1)'(1);
        end else if (pop) begin
            cnt_next = cnt_reg - (IDX_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[cnt_reg[IDX_W-1:0]] <= push_digit;
        end
    end

endmodule

`default_nettype wire
